FILE: design/vtcv_pkg.sv
// shared types and constants for the vertex transform, clip and viewport block
// no dependencies

package vtcv_pkg;

    // default for the largest surface dimension
    localparam int VT_MAX_DIM = 2048;

    // register indexes on the configuration port
    localparam logic [2:0] REG_ROW0  = 3'd0;
    localparam logic [2:0] REG_ROW1  = 3'd1;
    localparam logic [2:0] REG_ROW2  = 3'd2;
    localparam logic [2:0] REG_ROW3  = 3'd3;
    localparam logic [2:0] REG_SCR_W = 3'd4;
    localparam logic [2:0] REG_SCR_H = 3'd5;

    // reset values: identity matrix, 640 x 480 surface
    localparam logic [63:0] RST_ROW0  = 64'h0000_0000_0000_1000;
    localparam logic [63:0] RST_ROW1  = 64'h0000_0000_1000_0000;
    localparam logic [63:0] RST_ROW2  = 64'h0000_1000_0000_0000;
    localparam logic [63:0] RST_ROW3  = 64'h1000_0000_0000_0000;
    localparam logic [11:0] RST_SCR_W = 12'd640;
    localparam logic [11:0] RST_SCR_H = 12'd480;

    // input word: object-space vertex, signed Q8.8
    typedef struct packed {
        logic signed [15:0] obj_x;
        logic signed [15:0] obj_y;
        logic signed [15:0] obj_z;
    } t_vtx_in;

    // output word: screen position and visibility
    typedef struct packed {
        logic [11:0] pix_x;
        logic [11:0] pix_y;
        logic        visible;
    } t_vtx_out;

    // configuration seen by the datapath
    typedef struct packed {
        logic [3:0][63:0] row;
        logic [11:0]      scr_w;
        logic [11:0]      scr_h;
    } t_cfg;

endpackage

FILE: design/vtcv_regs.sv
// configuration registers on an apb-style port: matrix rows and surface size
// depends on vtcv_pkg

module vtcv_regs
    import vtcv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign idx   = paddr[5:3];
    assign wr_en = psel & penable & pwrite;

    // register writes, out-of-range indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row[0] <= RST_ROW0;
            r_cfg.row[1] <= RST_ROW1;
            r_cfg.row[2] <= RST_ROW2;
            r_cfg.row[3] <= RST_ROW3;
            r_cfg.scr_w  <= RST_SCR_W;
            r_cfg.scr_h  <= RST_SCR_H;
        end else if (wr_en) begin
            case (idx)
                REG_ROW0:  r_cfg.row[0] <= pwdata;
                REG_ROW1:  r_cfg.row[1] <= pwdata;
                REG_ROW2:  r_cfg.row[2] <= pwdata;
                REG_ROW3:  r_cfg.row[3] <= pwdata;
                REG_SCR_W: r_cfg.scr_w  <= pwdata[11:0];
                REG_SCR_H: r_cfg.scr_h  <= pwdata[11:0];
                default:   ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            REG_ROW0:  prdata = r_cfg.row[0];
            REG_ROW1:  prdata = r_cfg.row[1];
            REG_ROW2:  prdata = r_cfg.row[2];
            REG_ROW3:  prdata = r_cfg.row[3];
            REG_SCR_W: prdata = {52'd0, r_cfg.scr_w};
            REG_SCR_H: prdata = {52'd0, r_cfg.scr_h};
            default:   prdata = 64'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/vertex_transform_clip_viewport.sv
// throughput: one vertex per cycle while i_out_ready holds, over 18 register stages;
// 12 multipliers, then a 13-stage divider giving one quotient bit per stage for x and for y
// each stage advances when empty or when the stage after it advances
// reset (synchronous, active low) empties the pipeline and loads identity matrix, 640 x 480
// top level: matrix transform, clip test, perspective divide, viewport map; uses vtcv_pkg, vtcv_regs

module vertex_transform_clip_viewport
    import vtcv_pkg::*;
#(
    parameter int MAX_SCREEN_DIM = VT_MAX_DIM
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_vtx_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_vtx_out    o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int DIM_W = $clog2(MAX_SCREEN_DIM + 1);
    localparam int SUM_W = 34;
    localparam int REM_W = SUM_W + 1;
    localparam int QW    = 13;
    localparam int UW    = 14;
    localparam int PW    = UW + DIM_W + 12;
    localparam int NDIV  = QW;
    localparam int S_DIV = 3;
    localparam int S_OFS = S_DIV + NDIV;
    localparam int S_OUT = S_OFS + 1;
    localparam int NS    = S_OUT + 1;
    localparam logic [UW-1:0] ONE_Q = UW'(4096);

    t_cfg cfg;

    vtcv_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    assign pready = 1'b1;

    // stage valids and advance enables
    logic [NS-1:0] r_vld;
    logic [NS:0]   en;

    always_comb begin
        en[NS] = i_out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready = en[0];

    // surface size, saturated to the maximum
    logic [DIM_W+11:0] wide_w, wide_h;
    logic [DIM_W-1:0]  dim_w, dim_h;

    always_comb begin
        wide_w = (DIM_W + 12)'(cfg.scr_w);
        wide_h = (DIM_W + 12)'(cfg.scr_h);
        if (wide_w > (DIM_W + 12)'(MAX_SCREEN_DIM)) wide_w = (DIM_W + 12)'(MAX_SCREEN_DIM);
        if (wide_h > (DIM_W + 12)'(MAX_SCREEN_DIM)) wide_h = (DIM_W + 12)'(MAX_SCREEN_DIM);
        dim_w = wide_w[DIM_W-1:0];
        dim_h = wide_h[DIM_W-1:0];
    end

    // stage 0: twelve products for rows x, y, w
    logic signed [15:0] vec [4];
    logic signed [31:0] r_prod [3][4];
    logic [1:0]         row_sel [3];

    assign vec[0] = i_in_data.obj_x;
    assign vec[1] = i_in_data.obj_y;
    assign vec[2] = i_in_data.obj_z;
    assign vec[3] = 16'sd256;
    assign row_sel[0] = 2'd0;
    assign row_sel[1] = 2'd1;
    assign row_sel[2] = 2'd3;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[r][j] <= $signed(cfg.row[row_sel[r]][16*j +: 16]) * vec[j];
                end
            end
        end
    end

    // stage 1: clip coordinates
    logic signed [SUM_W-1:0] r_cx, r_cy, r_cw;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_cx <= SUM_W'(r_prod[0][0]) + SUM_W'(r_prod[0][1])
                  + SUM_W'(r_prod[0][2]) + SUM_W'(r_prod[0][3]);
            r_cy <= SUM_W'(r_prod[1][0]) + SUM_W'(r_prod[1][1])
                  + SUM_W'(r_prod[1][2]) + SUM_W'(r_prod[1][3]);
            r_cw <= SUM_W'(r_prod[2][0]) + SUM_W'(r_prod[2][1])
                  + SUM_W'(r_prod[2][2]) + SUM_W'(r_prod[2][3]);
        end
    end

    // stage 2: magnitudes, signs and clip test
    logic [SUM_W-1:0] mag_x, mag_y, mag_w;
    logic [SUM_W-1:0] r_mx, r_my, r_mw;
    logic             r_neg_x, r_neg_y, r_vis2;

    assign mag_x = r_cx[SUM_W-1] ? SUM_W'(-r_cx) : SUM_W'(r_cx);
    assign mag_y = r_cy[SUM_W-1] ? SUM_W'(-r_cy) : SUM_W'(r_cy);
    assign mag_w = r_cw[SUM_W-1] ? SUM_W'(-r_cw) : SUM_W'(r_cw);

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_mx    <= mag_x;
            r_my    <= mag_y;
            r_mw    <= mag_w;
            r_neg_x <= r_cx[SUM_W-1] ^ r_cw[SUM_W-1];
            r_neg_y <= r_cy[SUM_W-1] ^ r_cw[SUM_W-1];
            r_vis2  <= (r_cw != '0) && (mag_x <= mag_w) && (mag_y <= mag_w);
        end
    end

    // stages 3..15: restoring divide, one quotient bit per stage
    logic [REM_W-1:0] r_rx [NDIV];
    logic [REM_W-1:0] r_ry [NDIV];
    logic [QW-1:0]    r_qx [NDIV];
    logic [QW-1:0]    r_qy [NDIV];
    logic [SUM_W-1:0] r_d  [NDIV];
    logic             r_sx [NDIV];
    logic             r_sy [NDIV];
    logic             r_vs [NDIV];

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        logic [REM_W-1:0] ax, ay, tx, ty;
        logic [QW-1:0]    qx, qy;
        logic [SUM_W-1:0] d;
        logic             sx, sy, vs, gx, gy;

        // first stage takes the magnitudes unshifted, later stages shift the remainder
        if (k == 0) begin : g_head
            always_comb begin
                ax = {1'b0, r_mx};
                ay = {1'b0, r_my};
                qx = '0;
                qy = '0;
                d  = r_mw;
                sx = r_neg_x;
                sy = r_neg_y;
                vs = r_vis2;
                tx = ax;
                ty = ay;
            end
        end else begin : g_body
            always_comb begin
                ax = r_rx[k-1];
                ay = r_ry[k-1];
                qx = r_qx[k-1];
                qy = r_qy[k-1];
                d  = r_d[k-1];
                sx = r_sx[k-1];
                sy = r_sy[k-1];
                vs = r_vs[k-1];
                tx = {ax[REM_W-2:0], 1'b0};
                ty = {ay[REM_W-2:0], 1'b0};
            end
        end

        assign gx = tx >= {1'b0, d};
        assign gy = ty >= {1'b0, d};

        always_ff @(posedge i_clk) begin
            if (en[S_DIV+k]) begin
                r_rx[k] <= gx ? tx - {1'b0, d} : tx;
                r_ry[k] <= gy ? ty - {1'b0, d} : ty;
                r_qx[k] <= {qx[QW-2:0], gx};
                r_qy[k] <= {qy[QW-2:0], gy};
                r_d[k]  <= d;
                r_sx[k] <= sx;
                r_sy[k] <= sy;
                r_vs[k] <= vs;
            end
        end
    end

    // stage 16: shift normalized values to [0, 8192], y flipped
    logic [UW-1:0] r_ux, r_uy;
    logic          r_vis_o;

    always_ff @(posedge i_clk) begin
        if (en[S_OFS]) begin
            r_ux    <= r_sx[NDIV-1] ? ONE_Q - UW'(r_qx[NDIV-1]) : ONE_Q + UW'(r_qx[NDIV-1]);
            r_uy    <= r_sy[NDIV-1] ? ONE_Q + UW'(r_qy[NDIV-1]) : ONE_Q - UW'(r_qy[NDIV-1]);
            r_vis_o <= r_vs[NDIV-1];
        end
    end

    // stage 17: viewport scale into the output register
    logic [PW-1:0] prod_x, prod_y;
    t_vtx_out      r_out;

    assign prod_x = PW'(r_ux) * PW'(dim_w);
    assign prod_y = PW'(r_uy) * PW'(dim_h);

    always_ff @(posedge i_clk) begin
        if (en[S_OUT]) begin
            r_out.pix_x   <= r_vis_o ? prod_x[13 +: 12] : 12'd0;
            r_out.pix_y   <= r_vis_o ? prod_y[13 +: 12] : 12'd0;
            r_out.visible <= r_vis_o;
        end
    end

    assign o_out_valid = r_vld[NS-1];
    assign o_out_data  = r_out;

`ifndef SYNTH
    // a clipped word carries zero coordinates
    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.visible |-> o_out_data.pix_x == 12'd0
            && o_out_data.pix_y == 12'd0)
        else $error("clipped word with nonzero coordinates");

    // a visible vertex never divides to more than one
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_OFS-1] && r_vs[NDIV-1] |-> r_qx[NDIV-1] <= QW'(4096)
            && r_qy[NDIV-1] <= QW'(4096))
        else $error("quotient above one for a visible vertex");

    // an empty output stage never blocks the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");
`endif

endmodule
